// ===== hdl/dbh_pkg.sv =====
`default_nettype none

package dbh_pkg;

    typedef enum logic [1:0] {
        SIDE_NONE = 2'd0,
        SIDE_POS  = 2'd1,
        SIDE_NEG  = 2'd2
    } side_t;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int BAND_WIDTH      = 31;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BAND   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HYST   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/deadband_with_hysteresis.sv =====
`default_nettype none

// Deadband with hysteresis on a signed Q16.16 stream: each sample has the offset removed, passes
// through a deadband of half-width D with hysteresis eps (clamped to D) and has the offset added
// back, all sums saturating to DATA_WIDTH bits. One request is taken every cycle unless the output
// stalls; it passes through an input register and then a result register, from which it is offered; the
// single-pass shaping logic between them also updates the side state, so consecutive samples
// see each other's side without a bubble. Registers should be written only while the block is
// empty, and a write to index 3 is ignored.
module deadband_with_hysteresis #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cfg_we,
    input  wire logic [dbh_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  wire logic [(DATA_WIDTH > 31 ? DATA_WIDTH : 31)-1:0] cfg_data,
    input  wire logic                                     sample_valid,
    output logic                                          sample_ready,
    input  wire logic signed [DATA_WIDTH-1:0]             sample,
    output logic                                          shaped_valid,
    input  wire logic                                     shaped_ready,
    output logic signed [DATA_WIDTH-1:0]                  shaped
);

    logic [dbh_pkg::BAND_WIDTH-1:0] band_reg;
    logic [dbh_pkg::BAND_WIDTH-1:0] hyst_reg;
    logic signed [DATA_WIDTH-1:0]   offset_reg;
    dbh_pkg::side_t                 side_reg;
    dbh_pkg::side_t                 side_next;
    logic                           in_valid_reg;
    logic signed [DATA_WIDTH-1:0]   sample_reg;
    logic                           out_valid_reg;
    logic signed [DATA_WIDTH-1:0]   shaped_reg;
    logic signed [DATA_WIDTH-1:0]   shaped_next;
    logic                           stage_free;
    logic                           stage_move;

    assign stage_free   = !out_valid_reg || shaped_ready;
    assign stage_move   = in_valid_reg && stage_free;
    assign sample_ready = !in_valid_reg || stage_free;
    assign shaped_valid = out_valid_reg;
    assign shaped       = shaped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg   <= '0;
            hyst_reg   <= '0;
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dbh_pkg::REG_BAND:   band_reg   <= cfg_data[dbh_pkg::BAND_WIDTH-1:0];
                dbh_pkg::REG_HYST:   hyst_reg   <= cfg_data[dbh_pkg::BAND_WIDTH-1:0];
                dbh_pkg::REG_OFFSET: offset_reg <= $signed(cfg_data[DATA_WIDTH-1:0]);
                default:             ;
            endcase
        end
    end

    dbh_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .sample    (sample_reg),
        .band      (band_reg),
        .hyst      (hyst_reg),
        .offset    (offset_reg),
        .side      (side_reg),
        .shaped    (shaped_next),
        .side_next (side_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            side_reg      <= dbh_pkg::SIDE_NONE;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (stage_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (stage_move)
            begin
                side_reg <= side_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            sample_reg <= sample;
        end
        if (stage_move)
        begin
            shaped_reg <= shaped_next;
        end
    end

    // A held request must stay in the input register while the result is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !shaped_ready)
        |=> (in_valid_reg && $stable(sample_reg)))
    else $error("input register lost or changed a held request");

    // The side state moves only when a request passes into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !stage_move |=> $stable(side_reg))
    else $error("side state changed without a request passing");

    // A request passing from the input register always yields a result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_move |=> out_valid_reg)
    else $error("result missing after a request passed");

endmodule

`default_nettype wire

// ===== hdl/dbh_core.sv =====
`default_nettype none

module dbh_core #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic signed [DATA_WIDTH-1:0]         sample,
    input  wire logic        [dbh_pkg::BAND_WIDTH-1:0] band,
    input  wire logic        [dbh_pkg::BAND_WIDTH-1:0] hyst,
    input  wire logic signed [DATA_WIDTH-1:0]         offset,
    input  wire dbh_pkg::side_t                        side,
    output logic signed      [DATA_WIDTH-1:0]         shaped,
    output dbh_pkg::side_t                             side_next
);

    localparam int EW = (DATA_WIDTH > 32 ? DATA_WIDTH : 32) + 2;
    localparam logic signed [EW-1:0] MAXV =
        $signed({{(EW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [EW-1:0] MINV = ~MAXV;

    function automatic logic signed [EW-1:0] sat_dw(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] res;
        if (v > MAXV)
        begin
            res = MAXV;
        end
        else if (v < MINV)
        begin
            res = MINV;
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

    logic signed [EW-1:0] s_ext;
    logic signed [EW-1:0] o_ext;
    logic signed [EW-1:0] d;
    logic signed [EW-1:0] eps;
    logic signed [EW-1:0] e;
    logic signed [EW-1:0] sh;
    logic signed [EW-1:0] x;
    logic signed [EW-1:0] r;
    logic signed [EW-1:0] total;
    logic                 inband;
    logic                 e_zero;
    logic                 e_full;
    dbh_pkg::side_t       cur;

    assign s_ext  = EW'(sample);
    assign o_ext  = EW'(offset);
    assign d      = $signed(EW'(band));
    assign eps    = $signed(EW'(hyst));
    assign e      = (eps < d) ? eps : d;
    assign sh     = d - e;
    assign x      = sat_dw(s_ext - o_ext);
    assign inband = (x <= d) && (x >= -d);
    assign e_zero = (e == '0);
    assign e_full = (e == d);
    assign cur    = (side == dbh_pkg::SIDE_POS || side == dbh_pkg::SIDE_NEG)
                    ? side : dbh_pkg::SIDE_NONE;

    always_comb
    begin
        r         = '0;
        side_next = cur;
        if (inband && (e_zero || cur == dbh_pkg::SIDE_NONE))
        begin
            r = '0;
        end
        else if (e_zero)
        begin
            r = (x > d) ? sat_dw(x - d) : sat_dw(x + d);
        end
        else if (e_full)
        begin
            if (x >= d)
            begin
                r         = x;
                side_next = dbh_pkg::SIDE_POS;
            end
            else if (x <= -d)
            begin
                r         = x;
                side_next = dbh_pkg::SIDE_NEG;
            end
            else if (cur == dbh_pkg::SIDE_POS)
            begin
                if (x > 0)
                begin
                    r = x;
                end
                else
                begin
                    side_next = dbh_pkg::SIDE_NONE;
                end
            end
            else
            begin
                if (x < 0)
                begin
                    r = x;
                end
                else
                begin
                    side_next = dbh_pkg::SIDE_NONE;
                end
            end
        end
        else
        begin
            if (x >= d)
            begin
                r         = sat_dw(x - sh);
                side_next = dbh_pkg::SIDE_POS;
            end
            else if (x <= -d)
            begin
                r         = sat_dw(x + sh);
                side_next = dbh_pkg::SIDE_NEG;
            end
            else if (x <= sh && x >= -sh)
            begin
                side_next = dbh_pkg::SIDE_NONE;
            end
            else if (x > 0)
            begin
                if (cur == dbh_pkg::SIDE_POS)
                begin
                    r = sat_dw(x - sh);
                end
                else
                begin
                    side_next = dbh_pkg::SIDE_NONE;
                end
            end
            else
            begin
                if (cur == dbh_pkg::SIDE_NEG)
                begin
                    r = sat_dw(x + sh);
                end
                else
                begin
                    side_next = dbh_pkg::SIDE_NONE;
                end
            end
        end
    end

    assign total  = sat_dw(r + o_ext);
    assign shaped = total[DATA_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int DW = 32;
    localparam longint SHAPED_MAX = 64'sd2147483647;
    localparam longint SHAPED_MIN = -64'sd2147483648;
    localparam logic [dbh_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int STALL_CYCLES = 300;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 125;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [dbh_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [DW-1:0] cfg_data = '0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    logic signed [DW-1:0] sample = '0;
    logic shaped_valid;
    logic shaped_ready = 1'b0;
    logic signed [DW-1:0] shaped;

    logic signed [DW-1:0] samples_pending[$];
    logic signed [DW-1:0] shaped_expected[$];
    logic signed [DW-1:0] shaped_want;
    logic sample_taken = 1'b0;
    logic recv_hold = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    event hold_off_ev;

    logic [dbh_pkg::BAND_WIDTH-1:0] band_d = '0;
    logic [dbh_pkg::BAND_WIDTH-1:0] hyst_eps = '0;
    logic signed [DW-1:0] offset_v = '0;
    dbh_pkg::side_t side_q = dbh_pkg::SIDE_NONE;
    longint walk_x = 0;

    int errors = 0;
    int samples_sent = 0;
    int results_checked = 0;
    int settings_used = 1;
    int cycle_count = 0;

    deadband_with_hysteresis #(
        .DATA_WIDTH(DW)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample(sample),
        .shaped_valid(shaped_valid),
        .shaped_ready(shaped_ready),
        .shaped(shaped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sat_data(longint v);
        if (v > SHAPED_MAX)
            return SHAPED_MAX;
        if (v < SHAPED_MIN)
            return SHAPED_MIN;
        return v;
    endfunction

    function automatic logic signed [DW-1:0] shape_sample(logic signed [DW-1:0] s);
        longint d;
        longint e;
        longint x;
        longint sh;
        longint r;
        logic inband;
        d = band_d;
        e = (hyst_eps < band_d) ? hyst_eps : band_d;
        x = sat_data(longint'(s) - longint'(offset_v));
        inband = (x <= d) && (x >= -d);
        sh = d - e;
        r = 0;
        if (inband && (e == 0 || side_q == dbh_pkg::SIDE_NONE))
            r = 0;
        else if (e == 0)
            r = (x > d) ? sat_data(x - d) : sat_data(x + d);
        else if (e == d)
        begin
            if (x >= d)
            begin
                r = x;
                side_q = dbh_pkg::SIDE_POS;
            end
            else if (x <= -d)
            begin
                r = x;
                side_q = dbh_pkg::SIDE_NEG;
            end
            else if ((side_q == dbh_pkg::SIDE_POS && x > 0)
                     || (side_q != dbh_pkg::SIDE_POS && x < 0))
                r = x;
            else
            begin
                r = 0;
                side_q = dbh_pkg::SIDE_NONE;
            end
        end
        else
        begin
            if (x >= d)
            begin
                r = sat_data(x - sh);
                side_q = dbh_pkg::SIDE_POS;
            end
            else if (x <= -d)
            begin
                r = sat_data(x + sh);
                side_q = dbh_pkg::SIDE_NEG;
            end
            else if (x > sh && side_q == dbh_pkg::SIDE_POS)
                r = sat_data(x - sh);
            else if (x < -sh && side_q == dbh_pkg::SIDE_NEG)
                r = sat_data(x + sh);
            else
            begin
                r = 0;
                side_q = dbh_pkg::SIDE_NONE;
            end
        end
        r = sat_data(r + longint'(offset_v));
        return r[DW-1:0];
    endfunction

    // Most samples land near the band edges or follow a random walk across the band, so
    // that the side state is driven through all of its transitions.
    function automatic logic signed [DW-1:0] next_sample();
        longint d;
        longint sh;
        longint x;
        longint span;
        d = band_d;
        sh = d - ((hyst_eps < band_d) ? hyst_eps : band_d);
        case ($urandom_range(9))
            0:
                return $urandom;
            1:
            begin
                case ($urandom_range(3))
                    0: return SHAPED_MAX[DW-1:0];
                    1: return SHAPED_MIN[DW-1:0];
                    2: return '0;
                    default: return '1;
                endcase
            end
            2, 3:
            begin
                x = ($urandom_range(1) ? d : sh) + longint'($urandom_range(4)) - 2;
                if ($urandom_range(1))
                    x = -x;
            end
            default:
            begin
                span = d / 2 + 4;
                if (span > 32'h7FFF_FFFF)
                    span = 32'h7FFF_FFFF;
                x = longint'($urandom_range(span[31:0]));
                walk_x = $urandom_range(1) ? walk_x + x : walk_x - x;
                if (walk_x > 2 * d + 8 || walk_x < -2 * d - 8)
                    walk_x = 0;
                x = walk_x;
            end
        endcase
        x = sat_data(x + longint'(offset_v));
        return x[DW-1:0];
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("simulation failed");
            $finish;
        end
        sample_taken <= sample_valid && sample_ready;
        if (sample_valid && sample_ready)
        begin
            shaped_expected.push_back(shape_sample(sample));
            samples_sent++;
        end
        if (shaped_valid && shaped_ready)
        begin
            if (shaped_expected.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, shaped);
                errors++;
            end
            else
            begin
                shaped_want = shaped_expected.pop_front();
                results_checked++;
                if (shaped !== shaped_want)
                begin
                    $display("%0t: shaped mismatch, expected %h, actual %h",
                             $time, shaped_want, shaped);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!sample_valid || sample_taken)
            begin
                if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_valid <= 1'b1;
                    sample <= samples_pending.pop_front();
                end
                else
                    sample_valid <= 1'b0;
            end
            shaped_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The receiver refuses every result for a long stretch, so requests back up into the
    // block and its input stalls.
    always
    begin
        @(hold_off_ev);
        @(negedge clk);
        recv_hold <= 1'b1;
        repeat (STALL_CYCLES) @(negedge clk);
        recv_hold <= 1'b0;
    end

    task automatic write_reg(input logic [dbh_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [DW-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dbh_pkg::REG_BAND: band_d = val[dbh_pkg::BAND_WIDTH-1:0];
            dbh_pkg::REG_HYST: hyst_eps = val[dbh_pkg::BAND_WIDTH-1:0];
            dbh_pkg::REG_OFFSET: offset_v = val;
            default: ;
        endcase
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            IDLE_SEND:
            begin
                send_idle_pct = 63;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 63;
            end
            IDLE_BOTH:
            begin
                send_idle_pct = 19;
                recv_stall_pct = 19;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic drain();
        @(posedge clk);
        while (samples_pending.size() != 0 || sample_valid || shaped_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_setup();
        logic [DW-1:0] dv;
        logic [DW-1:0] ev;
        logic [DW-1:0] ov;
        case ($urandom_range(5))
            0: dv = '0;
            1: dv = $urandom_range(1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
            2: dv = $urandom;
            default: dv = $urandom_range(32'h0004_0000);
        endcase
        case ($urandom_range(3))
            0: ev = '0;
            1: ev = dv;
            2: ev = $urandom;
            default: ev = $urandom_range(dv[30:0]);
        endcase
        case ($urandom_range(5))
            0: ov = $urandom;
            1: ov = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: ov = 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
        endcase
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, $urandom);
        write_reg(dbh_pkg::REG_BAND, dv);
        write_reg(dbh_pkg::REG_HYST, ev);
        write_reg(dbh_pkg::REG_OFFSET, ov);
        settings_used++;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_idling(IDLE_NONE);

        @(posedge clk);
        samples_pending.push_back(32'h7FFF_FFFF);
        samples_pending.push_back(32'h8000_0000);
        samples_pending.push_back(32'h0000_0000);
        samples_pending.push_back(32'hFFFF_FFFF);
        drain();

        // Top bit of the band write is dropped, leaving a band of 1.0 with no hysteresis.
        write_reg(dbh_pkg::REG_BAND, 32'h8001_0000);
        write_reg(dbh_pkg::REG_OFFSET, 32'h0002_0000);
        settings_used++;
        @(posedge clk);
        samples_pending.push_back(32'h0002_8000);
        samples_pending.push_back(32'h0005_0000);
        samples_pending.push_back(32'hFFFF_0000);
        samples_pending.push_back(32'h7FFF_FFFF);
        samples_pending.push_back(32'h8000_0000);
        drain();

        // Hysteresis wider than the band is clamped, which gives the bowtie shape.
        write_reg(dbh_pkg::REG_HYST, 32'h7FFF_FFFF);
        write_reg(dbh_pkg::REG_OFFSET, 32'h0000_0000);
        settings_used++;
        @(posedge clk);
        samples_pending.push_back(32'h0000_8000);
        samples_pending.push_back(32'h0001_0000);
        samples_pending.push_back(32'h0000_8000);
        samples_pending.push_back(32'hFFFF_C000);
        samples_pending.push_back(32'hFFFE_8000);
        samples_pending.push_back(32'hFFFF_8000);
        samples_pending.push_back(32'h0000_0000);
        drain();

        // Partial hysteresis, entered with the input exactly on the band edge.
        write_reg(dbh_pkg::REG_HYST, 32'h0000_4000);
        settings_used++;
        @(posedge clk);
        samples_pending.push_back(32'h0001_0000);
        samples_pending.push_back(32'h0000_E666);
        samples_pending.push_back(32'h0000_8000);
        samples_pending.push_back(32'h0000_E666);
        samples_pending.push_back(32'hFFFF_0000);
        samples_pending.push_back(32'hFFFF_199A);
        drain();

        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(dbh_pkg::REG_BAND, 32'h0000_0000);
        write_reg(dbh_pkg::REG_HYST, 32'h0000_0000);
        write_reg(dbh_pkg::REG_OFFSET, 32'h8000_0000);
        settings_used++;
        @(posedge clk);
        samples_pending.push_back(32'h7FFF_FFFF);
        samples_pending.push_back(32'h8000_0000);
        samples_pending.push_back(32'h0000_0000);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_setup();
            @(posedge clk);
            set_idling(p % 4);
            if (p == 4)
                -> hold_off_ev;
            for (int i = 0; i < PHASE_ITEMS; i++)
                samples_pending.push_back(next_sample());
            drain();
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d samples under %0d register settings and four idling patterns.",
                 samples_sent, settings_used);
        $display("Checked %0d shaped results, with %0d mismatches.", results_checked, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dbh_pkg.sv
hdl/dbh_core.sv
hdl/deadband_with_hysteresis.sv
sim/tb.sv
